/* rtl/tca_pkg.sv */
`timescale 1ns / 1ps

package tca_pkg;

    // Port word width and rule width
    localparam int ROW_W  = 64;
    localparam int RULE_W = 18;

    // Configuration register indexes
    localparam logic CFG_RULE = 1'b0;
    localparam logic CFG_NBHD = 1'b1;

    // Neighborhood shapes
    typedef enum logic [1:0] {
        NB_RECT = 2'd0,
        NB_DIAG = 2'd1,
        NB_HEX  = 2'd2,
        NB_ALL  = 2'd3
    } nbhd_t;

    // Per-column view handed between adjacent cells
    typedef struct packed {
        logic above;
        logic centre;
        logic below;
    } cell_nb_t;

    // Row-wide steering from the controller to every cell
    typedef struct packed {
        logic load;             // shift: upper <= middle, middle <= input row
        logic above_from_row;   // above taken from input row (first or second row of plane)
        logic centre_from_row;  // centre taken from input row (single-row plane)
        logic flush;            // final row: above and below both from upper
    } cell_ctl_t;

endpackage

/* rtl/tca_cell.sv */
`timescale 1ns / 1ps

module tca_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tca_pkg::cell_ctl_t         ctl,
    input  logic                       row_bit,
    input  logic [tca_pkg::RULE_W-1:0] rule_bits,
    input  tca_pkg::nbhd_t             nbhd,
    input  logic                       parity,
    input  tca_pkg::cell_nb_t          west,
    input  tca_pkg::cell_nb_t          east,
    output tca_pkg::cell_nb_t          own,
    output logic                       new_bit
);
    import tca_pkg::*;

    logic       upper_reg;
    logic       middle_reg;
    logic [3:0] sum;
    logic [4:0] idx;

    // Column slice of the two line buffers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            upper_reg  <= middle_reg;
            middle_reg <= row_bit;
        end
    end

    // Pick the three vertical taps of this column
    always_comb
    begin
        if (ctl.flush)
        begin
            own.above  = upper_reg;
            own.centre = middle_reg;
            own.below  = upper_reg;
        end
        else
        begin
            own.above  = ctl.above_from_row ? row_bit : upper_reg;
            own.centre = ctl.centre_from_row ? row_bit : middle_reg;
            own.below  = row_bit;
        end
    end

    // Live neighbor count for the selected shape
    always_comb
    begin
        unique case (nbhd)
            NB_RECT:
                sum = 4'(own.above) + 4'(own.below) + 4'(west.centre) + 4'(east.centre);
            NB_DIAG:
                sum = 4'(west.above) + 4'(east.above) + 4'(west.below) + 4'(east.below);
            NB_HEX:
                sum = 4'(own.above) + 4'(own.below)
                    + 4'(parity ? east.above : west.above)
                    + 4'(parity ? east.below : west.below)
                    + 4'(west.centre) + 4'(east.centre);
            default:
                sum = 4'(own.above) + 4'(own.below)
                    + 4'(west.above) + 4'(east.above)
                    + 4'(west.below) + 4'(east.below)
                    + 4'(west.centre) + 4'(east.centre);
        endcase
    end

    // Rule lookup at 2*sum + centre
    assign idx     = {sum, own.centre};
    assign new_bit = rule_bits[idx];

endmodule

/* rtl/tca_out_buf.sv */
`timescale 1ns / 1ps

module tca_out_buf (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [tca_pkg::ROW_W-1:0] push_row,
    input  logic                      push_end,
    output logic                      space,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tca_pkg::ROW_W-1:0] next_row,
    output logic                      plane_end
);
    import tca_pkg::*;

    logic [ROW_W-1:0] row_mem [2];
    logic             end_mem [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign next_row  = row_mem[rd_ptr_reg];
    assign plane_end = end_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            row_mem[wr_ptr_reg] <= push_row;
            end_mem[wr_ptr_reg] <= push_end;
        end
    end

endmodule

/* rtl/totalistic_ca_row_generator.sv */
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// ------    ---------           -------
// in        in_valid/in_ready   row_cells[63:0], last_row
// out       out_valid/out_ready next_row[63:0], plane_end
// cfg       cfg_write           cfg_index (0 rule_bits, 1 neighbourhood), cfg_data[17:0]
//
// One row per cycle while in_ready is high; a result appears the cycle after the transfer that causes it.
// A last row that follows held rows adds a flush step, during which in_ready is low,
// because the cell chain produces one row per cycle.
// Reset empties the line buffers and the two-entry output buffer; no clearing pass.
// in_ready drops only while the output buffer is full or the flush cycle runs.
module totalistic_ca_row_generator #(
    parameter int ROW_CELLS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tca_pkg::ROW_W-1:0]  row_cells,
    input  logic                       last_row,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tca_pkg::ROW_W-1:0]  next_row,
    output logic                       plane_end,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [tca_pkg::RULE_W-1:0] cfg_data
);
    import tca_pkg::*;

    typedef enum logic [3:0] {
        ST_EMPTY = 4'b0001,
        ST_ONE   = 4'b0010,
        ST_TWO   = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                parity_reg;
    logic                parity_next;
    logic [RULE_W-1:0]   rule_reg;
    nbhd_t               nbhd_reg;

    logic                in_xfer;
    logic                space;
    logic                push;
    logic                push_end;
    cell_ctl_t           ctl;
    cell_nb_t            nb [ROW_CELLS];
    logic [ROW_CELLS-1:0] gen_row;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg <= '0;
            nbhd_reg <= NB_RECT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RULE: rule_reg <= cfg_data;
                default:  nbhd_reg <= nbhd_t'(cfg_data[1:0]);
            endcase
        end
    end

    assign in_ready = (state_reg != ST_FLUSH) && space;
    assign in_xfer  = in_valid && in_ready;

    // Row sequencing
    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        push_end   = 1'b0;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (in_xfer)
                begin
                    push       = last_row;
                    push_end   = last_row;
                    state_next = last_row ? ST_EMPTY : ST_ONE;
                end
            end
            ST_ONE, ST_TWO:
            begin
                if (in_xfer)
                begin
                    push       = 1'b1;
                    state_next = last_row ? ST_FLUSH : ST_TWO;
                end
            end
            default:
            begin
                if (space)
                begin
                    push       = 1'b1;
                    push_end   = 1'b1;
                    state_next = ST_EMPTY;
                end
            end
        endcase
        if (push)
        begin
            parity_next = push_end ? 1'b0 : ~parity_reg;
        end
        else
        begin
            parity_next = parity_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_EMPTY;
            parity_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            parity_reg <= parity_next;
        end
    end

    // Steering shared by all cells
    always_comb
    begin
        ctl.load            = in_xfer;
        ctl.above_from_row  = (state_reg != ST_TWO);
        ctl.centre_from_row = (state_reg == ST_EMPTY);
        ctl.flush           = (state_reg == ST_FLUSH);
    end

    // Chain of column cells; edge columns reflect
    for (genvar b = 0; b < ROW_CELLS; b++)
    begin : g_cell
        localparam int WEST_IDX = (b == ROW_CELLS - 1) ? ROW_CELLS - 2 : b + 1;
        localparam int EAST_IDX = (b == 0) ? 1 : b - 1;

        tca_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .row_bit   (row_cells[b]),
            .rule_bits (rule_reg),
            .nbhd      (nbhd_reg),
            .parity    (parity_reg),
            .west      (nb[WEST_IDX]),
            .east      (nb[EAST_IDX]),
            .own       (nb[b]),
            .new_bit   (gen_row[b])
        );
    end

    tca_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_row  (ROW_W'(gen_row)),
        .push_end  (push_end),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .next_row  (next_row),
        .plane_end (plane_end)
    );

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_flush_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_row && (state_reg != ST_EMPTY)) |=> (state_reg == ST_FLUSH))
        else $error("last row after held rows did not enter flush");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result pushed into a full output buffer");

    a_parity_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMPTY) |-> !parity_reg)
        else $error("row parity not cleared between planes");

    a_flush_emits_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FLUSH) && space) |-> (push && push_end))
        else $error("flush cycle did not emit the final row");

endmodule

/* tb/sv/row_board_pkg.sv */
`timescale 1ns / 1ps

package row_board_pkg;

    import tca_pkg::*;

    // One next-generation row as it should leave the block
    typedef struct {
        logic [ROW_W-1:0] cells;
        logic             plane_end;
    } gen_row_t;

    class row_board;

        // Copy of the configuration registers
        logic [RULE_W-1:0] rule;
        nbhd_t             shape;

        // Line buffers and plane position
        logic [ROW_W-1:0]  upper;
        logic [ROW_W-1:0]  middle;
        int                rows_held;
        logic              odd_row;

        gen_row_t          pending_rows[$];
        int                errors;

        function new();
            rule      = '0;
            shape     = NB_RECT;
            upper     = '0;
            middle    = '0;
            rows_held = 0;
            odd_row   = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic idx, logic [RULE_W-1:0] value);
            if (idx == CFG_RULE)
                rule = value;
            else
                shape = nbhd_t'(value[1:0]);
        endfunction

        function int pending();
            return pending_rows.size();
        endfunction

        // cell c gets cell c+1; last cell reflects to the one before it
        function logic [ROW_W-1:0] from_west(logic [ROW_W-1:0] x);
            return {x[ROW_W-2], x[ROW_W-1:1]};
        endfunction

        // cell c gets cell c-1; cell 0 reflects to cell 1
        function logic [ROW_W-1:0] from_east(logic [ROW_W-1:0] x);
            return {x[ROW_W-2:0], x[1]};
        endfunction

        // Totalistic update of one row: rule bit 2*sum+centre per cell
        function logic [ROW_W-1:0] next_generation(logic [ROW_W-1:0] above,
                                                   logic [ROW_W-1:0] centre,
                                                   logic [ROW_W-1:0] below);
            logic [ROW_W-1:0] nb [8];
            logic [ROW_W-1:0] result;
            int               count;
            int               sum;
            int               idx;
            case (shape)
                NB_RECT:
                begin
                    nb[0] = above;
                    nb[1] = below;
                    nb[2] = from_west(centre);
                    nb[3] = from_east(centre);
                    count = 4;
                end
                NB_DIAG:
                begin
                    nb[0] = from_west(above);
                    nb[1] = from_east(above);
                    nb[2] = from_west(below);
                    nb[3] = from_east(below);
                    count = 4;
                end
                NB_HEX:
                begin
                    // shifted pair leans west on even rows, east on odd rows
                    nb[0] = above;
                    nb[1] = below;
                    nb[2] = odd_row ? from_east(above) : from_west(above);
                    nb[3] = odd_row ? from_east(below) : from_west(below);
                    nb[4] = from_west(centre);
                    nb[5] = from_east(centre);
                    count = 6;
                end
                default:
                begin
                    nb[0] = above;
                    nb[1] = below;
                    nb[2] = from_west(above);
                    nb[3] = from_east(above);
                    nb[4] = from_west(below);
                    nb[5] = from_east(below);
                    nb[6] = from_west(centre);
                    nb[7] = from_east(centre);
                    count = 8;
                end
            endcase
            for (int b = 0; b < ROW_W; b++)
            begin
                sum = 0;
                for (int k = 0; k < count; k++)
                    sum += int'(nb[k][b]);
                idx = 2 * sum + int'(centre[b]);
                result[b] = rule[idx];
            end
            return result;
        endfunction

        function void push_row(logic [ROW_W-1:0] above, logic [ROW_W-1:0] centre,
                               logic [ROW_W-1:0] below, logic last_out);
            gen_row_t item;
            item.cells     = next_generation(above, centre, below);
            item.plane_end = last_out;
            pending_rows.push_back(item);
            odd_row = ~odd_row;
        endfunction

        // Accepted input row: advance the line buffers, queue what it releases
        function void note_input_row(logic [ROW_W-1:0] row, logic last);
            if (rows_held == 0)
            begin
                if (!last)
                begin
                    middle    = row;
                    rows_held = 1;
                    return;
                end
                // single-row plane: the row is its own upper and lower neighbor
                push_row(row, row, row, 1'b1);
            end
            else
            begin
                // second row of a plane reflects the top edge onto the row below
                push_row((rows_held >= 2) ? upper : row, middle, row, 1'b0);
                if (!last)
                begin
                    upper     = middle;
                    middle    = row;
                    rows_held = 2;
                    return;
                end
                // final row: bottom edge reflects onto the row above it
                push_row(middle, row, middle, 1'b1);
            end
            rows_held = 0;
            odd_row   = 1'b0;
        endfunction

        task report(string what, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
            $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
            errors++;
        endtask

        // Accepted output row against the oldest queued row
        task check_output_row(logic [ROW_W-1:0] got_row, logic got_end);
            gen_row_t want;
            if (pending_rows.size() == 0)
            begin
                report("row with nothing queued", got_row, '0);
                return;
            end
            want = pending_rows.pop_front();
            if (got_row !== want.cells)
                report("next_row", got_row, want.cells);
            if (got_end !== want.plane_end)
                report("plane_end", ROW_W'(got_end), ROW_W'(want.plane_end));
        endtask

    endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import tca_pkg::*;
    import row_board_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int SEGMENT_ROWS  = 60;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [ROW_W-1:0]  row_cells = '0;
    logic              last_row  = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ROW_W-1:0]  next_row;
    logic              plane_end;
    logic              cfg_write = 1'b0;
    logic              cfg_index = CFG_RULE;
    logic [RULE_W-1:0] cfg_data  = '0;

    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_left      = 0;
    bit       hold_request   = 1'b0;
    int       quiet_cycles   = 0;
    row_board board;

    totalistic_ca_row_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .row_cells (row_cells),
        .last_row  (last_row),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .next_row  (next_row),
        .plane_end (plane_end),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Output side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Output transfers go to the board
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_output_row(next_row, plane_end);
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d rows still queued",
                         quiet_cycles, board.pending());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Offer one row; returns at the falling edge after its transfer
    task automatic send_row(input logic [ROW_W-1:0] row, input logic last);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        row_cells <= row;
        last_row  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input_row(row, last);
        @(negedge clk);
    endtask

    // Stop offering and wait until every queued row has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Both registers, one write per cycle
    task automatic write_config(input logic [RULE_W-1:0] rule, input nbhd_t shape);
        cfg_write <= 1'b1;
        cfg_index <= CFG_RULE;
        cfg_data  <= rule;
        board.set_reg(CFG_RULE, rule);
        @(negedge clk);
        cfg_index <= CFG_NBHD;
        cfg_data  <= RULE_W'(shape);
        board.set_reg(CFG_NBHD, RULE_W'(shape));
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Mix of dense, sparse, solid and fully random rows
    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return a & b & {$urandom, $urandom};
            3, 4:    return a | b;
            5:       return a & b;
            6:       return a | {1'b1, {(ROW_W-2){1'b0}}, 1'b1};
            default: return a;
        endcase
    endfunction

    task automatic send_plane(input int len);
        for (int i = 0; i < len; i++)
            send_row(random_row(), i == len - 1);
    endtask

    // Stimulus
    initial
    begin
        int               rows_left;
        int               len;
        logic [RULE_W-1:0] rule_word;

        board = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // rectangular, rule all ones: solid and empty rows
        write_config('1, NB_RECT);
        send_row('0, 1'b0);
        send_row('1, 1'b0);
        send_row('0, 1'b1);
        settle();

        // rectangular, mixed rule: single cells at both edges
        write_config(18'h155AA, NB_RECT);
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row('1, 1'b0);
        send_row(64'h0000_0000_0000_0001, 1'b1);
        settle();

        // diagonal: edge cells and checkerboards
        write_config(18'h0B6D9, NB_DIAG);
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row(64'h0000_0000_0000_0001, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        settle();

        // hexagonal: enough rows for both row parities and the flush
        write_config(18'h2C5A3, NB_HEX);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row('1, 1'b0);
        send_row(64'h0123_4567_89AB_CDEF, 1'b0);
        send_row('0, 1'b0);
        send_row(64'hFEDC_BA98_7654_3210, 1'b1);
        settle();

        // all eight, rule zero: single-row plane
        write_config('0, NB_ALL);
        send_row('1, 1'b1);
        settle();

        // all eight: single-row plane, then a two-row plane
        write_config(18'h1D3B7, NB_ALL);
        send_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b1);
        send_row(64'hC000_0000_0000_0003, 1'b0);
        send_row(64'h4000_0000_0000_0002, 1'b1);
        settle();

        // random planes under four idling patterns
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default:
                begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            for (int seg = 0; seg < 6; seg++)
            begin
                settle();
                if (seg == 5)
                    rule_word = phase[0] ? '1 : '0;
                else
                    rule_word = RULE_W'($urandom_range(0, (1 << RULE_W) - 1));
                write_config(rule_word, nbhd_t'((phase * 6 + seg) % 4));
                // long output hold-off while rows keep coming
                if ((phase == 0 && seg == 2) || (phase == 3 && seg == 4))
                    hold_request = 1'b1;
                rows_left = SEGMENT_ROWS;
                while (rows_left > 0)
                begin
                    case ($urandom_range(0, 15))
                        0:       len = 1;
                        1:       len = 2;
                        default: len = $urandom_range(3, 14);
                    endcase
                    if (len > rows_left)
                        len = rows_left;
                    send_plane(len);
                    rows_left -= len;
                end
            end
        end

        // drain and verdict
        settle();
        repeat (8) @(negedge clk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
